// File: hdl/epr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the echo range/dwell tracker.
// Used by the channel interfaces, the top level and the checker; depends on nothing.
package epr_pkg;

  localparam int NumChannels = 4;

  localparam int OpW     = 2;
  localparam int ChanW   = 2;
  localparam int CountW  = 16;
  localparam int TickW   = 32;
  localparam int DistW   = 14;
  localparam int CfgIdxW = 2;

  typedef enum logic [OpW-1:0] {
    OpEdge  = 2'd0,
    OpRange = 2'd1,
    OpTrig  = 2'd2
  } op_e;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgRangeLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRangeHigh = 2'd1;

  localparam logic [DistW-1:0] RangeLowRst  = 14'd20;
  localparam logic [DistW-1:0] RangeHighRst = 14'd1000;

  // distance = floor(width * 34 / 200) = floor(width * 17 / 100), done as a
  // multiply by ceil(2^24 * 17 / 100) and a shift; exact for all 16-bit widths
  localparam int DistMulW  = 22;
  localparam int DistShift = 24;
  localparam int ProdW     = CountW + DistMulW;
  localparam logic [DistMulW-1:0] DistMul = 22'd2852127;

  // one transaction's state result, carried from the update stage to the
  // distance stage
  typedef struct packed {
    logic [ChanW-1:0]  chan;
    logic              ok;
    logic [CountW-1:0] width;
    logic              entered;
    logic              done;
    logic [TickW-1:0]  dwell;
    logic [DistW-1:0]  entry_dist;
  } res_t;

  function automatic logic [DistW-1:0] dist_of(input logic [CountW-1:0] w);
    logic [ProdW-1:0] p;
    p = ProdW'(w) * ProdW'(DistMul);
    return p[DistShift +: DistW];
  endfunction

  function automatic logic in_window(input logic [DistW-1:0] d,
                                     input logic [DistW-1:0] lo,
                                     input logic [DistW-1:0] hi);
    return (d > lo) && (d <= hi);
  endfunction

endpackage

// File: hdl/epr_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: echo items in, results out, config writes.
// Depends on epr_pkg for field widths.
interface epr_in_if import epr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OpW-1:0]    operation;
  logic [ChanW-1:0]  channel;
  logic              echo_level;
  logic [CountW-1:0] timer_count;
  logic [TickW-1:0]  tick_now;

  modport source (output valid, operation, channel, echo_level, timer_count, tick_now,
                  input ready);
  modport sink (input valid, operation, channel, echo_level, timer_count, tick_now,
                output ready);
  modport mon (input valid, ready, operation, channel, echo_level, timer_count,
               tick_now);
endinterface

interface epr_res_if import epr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ChanW-1:0]  result_channel;
  logic [CountW-1:0] echo_width;
  logic [DistW-1:0]  distance;
  logic              in_range;
  logic              entered;
  logic              dwell_done;
  logic [TickW-1:0]  dwell_ticks;
  logic [DistW-1:0]  entry_distance;

  modport source (output valid, result_channel, echo_width, distance, in_range, entered,
                  dwell_done, dwell_ticks, entry_distance, input ready);
  modport sink (input valid, result_channel, echo_width, distance, in_range, entered,
                dwell_done, dwell_ticks, entry_distance, output ready);
  modport mon (input valid, ready, result_channel, echo_width, distance, in_range,
               entered, dwell_done, dwell_ticks, entry_distance);
endinterface

interface epr_cfg_if import epr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [DistW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
  modport mon (input valid, ready, index, data);
endinterface

// File: hdl/echo_pulse_range_dwell_tracker.sv
`timescale 1ns / 1ps
// Echo range/dwell tracker top level. A result passes the input register, the
// state update and the distance stage in turn before it is offered.
// Throughput: one item per cycle while results are taken; the per-channel
// register file is read and written in the single update stage, so items never
// wait on each other. Reset: asynchronous, active low; clears all channel state
// to zero, sets the window to 20..1000 and empties the pipeline.
module echo_pulse_range_dwell_tracker import epr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  epr_in_if.sink    in_i,
  epr_res_if.source res_o,
  epr_cfg_if.sink   cfg_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers: ready is always high, and a write takes effect in the following cycle
  // ---------------------------------------------------------------------------
  logic [DistW-1:0] range_low_q, range_high_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q  <= RangeLowRst;
      range_high_q <= RangeHighRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgRangeLow:  range_low_q  <= cfg_i.data;
        CfgRangeHigh: range_high_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake: each stage takes a new transaction when it is empty or its
  // content moves on; a waiting result blocks input only once the pipe is full.
  // ---------------------------------------------------------------------------
  logic s0_v_q, s1_v_q, out_v_q;
  logic s0_rdy, s1_rdy, s2_rdy;
  logic s0_fire, s1_fire;

  assign s2_rdy  = !out_v_q || res_o.ready;
  assign s1_rdy  = !s1_v_q || s2_rdy;
  assign s0_rdy  = !s0_v_q || s1_rdy;
  assign s0_fire = s0_v_q && s1_rdy;
  assign s1_fire = s1_v_q && s2_rdy;

  assign in_i.ready = s0_rdy;

  // ---------------------------------------------------------------------------
  // Stage 0: input register
  // ---------------------------------------------------------------------------
  logic [OpW-1:0]    s0_op_q;
  logic [ChanW-1:0]  s0_ch_q;
  logic              s0_lvl_q;
  logic [CountW-1:0] s0_cnt_q;
  logic [TickW-1:0]  s0_tick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (s0_rdy) begin
      s0_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && s0_rdy) begin
      s0_op_q   <= in_i.operation;
      s0_ch_q   <= in_i.channel;
      s0_lvl_q  <= in_i.echo_level;
      s0_cnt_q  <= in_i.timer_count;
      s0_tick_q <= in_i.tick_now;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-channel state. dist_q caches the distance of width_q; it is written after
  // the width, as the transaction leaves stage 1, and bypassed from there.
  // ---------------------------------------------------------------------------
  logic [CountW-1:0] rise_q   [NumChannels];
  logic [CountW-1:0] fall_q   [NumChannels];
  logic [CountW-1:0] width_q  [NumChannels];
  logic [TickW-1:0]  etick_q  [NumChannels];
  logic [DistW-1:0]  edist_q  [NumChannels];
  logic [TickW-1:0]  dwell_q  [NumChannels];
  logic [DistW-1:0]  dist_q   [NumChannels];

  logic [CountW-1:0] rise_d   [NumChannels];
  logic [CountW-1:0] fall_d   [NumChannels];
  logic [CountW-1:0] width_d  [NumChannels];
  logic [TickW-1:0]  etick_d  [NumChannels];
  logic [DistW-1:0]  edist_d  [NumChannels];
  logic [TickW-1:0]  dwell_d  [NumChannels];

  res_t             s1_q, s1_d;
  logic [DistW-1:0] fwd_dist;
  logic [DistW-1:0] cur_dist;
  logic             ch_ok;
  logic             hold;
  logic             entered, done;

  // distance of the width held in stage 1: feeds the result, the cache and
  // the bypass into the range decision
  assign fwd_dist = dist_of(s1_q.width);

  assign ch_ok = int'(s0_ch_q) < NumChannels;

  // newest distance for the addressed channel: take it from stage 1 when that
  // transaction touched the same channel, otherwise from the cache
  assign cur_dist = (s1_v_q && s1_q.ok && (s1_q.chan == s0_ch_q)) ? fwd_dist
                                                                 : dist_q[s0_ch_q];
  assign hold     = in_window(cur_dist, range_low_q, range_high_q);

  // ---------------------------------------------------------------------------
  // Stage 1 update: apply the transaction to the channel state
  // ---------------------------------------------------------------------------
  always_comb begin
    rise_d  = rise_q;
    fall_d  = fall_q;
    width_d = width_q;
    etick_d = etick_q;
    edist_d = edist_q;
    dwell_d = dwell_q;
    entered = 1'b0;
    done    = 1'b0;
    if (s0_fire && ch_ok) begin
      case (op_e'(s0_op_q))
        OpEdge: begin
          if (s0_lvl_q) begin
            rise_d[s0_ch_q] = s0_cnt_q;
          end else begin
            fall_d[s0_ch_q] = s0_cnt_q;
            // no rise captured: width drops to zero; rise at or after fall (timer
            // wrapped): keep the old width
            if (rise_q[s0_ch_q] == '0) begin
              width_d[s0_ch_q] = '0;
            end else if (rise_q[s0_ch_q] < s0_cnt_q) begin
              width_d[s0_ch_q] = s0_cnt_q - rise_q[s0_ch_q];
            end
          end
        end
        OpTrig: begin
          for (int k = 0; k < NumChannels; k++) begin
            rise_d[k] = '0;
            fall_d[k] = '0;
          end
        end
        OpRange: begin
          // an entry tick of zero marks the channel as not tracking
          if ((etick_q[s0_ch_q] == '0) && hold) begin
            etick_d[s0_ch_q] = s0_tick_q;
            edist_d[s0_ch_q] = cur_dist;
            entered          = 1'b1;
          end else if ((etick_q[s0_ch_q] != '0) && !hold) begin
            dwell_d[s0_ch_q] = s0_tick_q - etick_q[s0_ch_q];
            etick_d[s0_ch_q] = '0;
            done             = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // report the addressed channel as it stands after the transaction
  always_comb begin
    s1_d.chan       = s0_ch_q;
    s1_d.ok         = ch_ok;
    s1_d.entered    = entered;
    s1_d.done       = done;
    s1_d.width      = ch_ok ? width_d[s0_ch_q] : '0;
    s1_d.dwell      = ch_ok ? dwell_d[s0_ch_q] : '0;
    s1_d.entry_dist = ch_ok ? edist_d[s0_ch_q] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumChannels; k++) begin
        rise_q[k]  <= '0;
        fall_q[k]  <= '0;
        width_q[k] <= '0;
        etick_q[k] <= '0;
        edist_q[k] <= '0;
        dwell_q[k] <= '0;
        dist_q[k]  <= '0;
      end
    end else begin
      rise_q  <= rise_d;
      fall_q  <= fall_d;
      width_q <= width_d;
      etick_q <= etick_d;
      edist_q <= edist_d;
      dwell_q <= dwell_d;
      // refresh the distance cache in transaction order
      if (s1_fire && s1_q.ok) begin
        dist_q[s1_q.chan] <= fwd_dist;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_q <= s0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_fire) begin
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: distance, window check and the result register
  // ---------------------------------------------------------------------------
  logic [ChanW-1:0]  out_ch_q;
  logic [CountW-1:0] out_width_q;
  logic [DistW-1:0]  out_dist_q;
  logic              out_inr_q;
  logic              out_ent_q;
  logic              out_done_q;
  logic [TickW-1:0]  out_dwell_q;
  logic [DistW-1:0]  out_edist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s2_rdy) begin
      out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_ch_q    <= s1_q.chan;
      out_width_q <= s1_q.width;
      out_dist_q  <= fwd_dist;
      out_inr_q   <= s1_q.ok && in_window(fwd_dist, range_low_q, range_high_q);
      out_ent_q   <= s1_q.entered;
      out_done_q  <= s1_q.done;
      out_dwell_q <= s1_q.dwell;
      out_edist_q <= s1_q.entry_dist;
    end
  end

  assign res_o.valid          = out_v_q;
  assign res_o.result_channel = out_ch_q;
  assign res_o.echo_width     = out_width_q;
  assign res_o.distance       = out_dist_q;
  assign res_o.in_range       = out_inr_q;
  assign res_o.entered        = out_ent_q;
  assign res_o.dwell_done     = out_done_q;
  assign res_o.dwell_ticks    = out_dwell_q;
  assign res_o.entry_distance = out_edist_q;

endmodule

// File: hdl/epr_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the echo range/dwell tracker, bound to the top level.
// Depends on epr_pkg and the result channel of the top level.
module epr_checker import epr_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              res_valid_i,
  input logic              res_ready_i,
  input logic [ChanW-1:0]  res_chan_i,
  input logic [CountW-1:0] res_width_i,
  input logic [DistW-1:0]  res_dist_i,
  input logic              res_in_range_i,
  input logic              res_entered_i,
  input logic              res_done_i,
  input logic [TickW-1:0]  res_dwell_i,
  input logic [DistW-1:0]  res_edist_i
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable({res_chan_i, res_width_i, res_dist_i,
      res_in_range_i, res_entered_i, res_done_i, res_dwell_i, res_edist_i}))
    else $error("result payload changed while stalled");

  // a range update starts or ends tracking, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> !(res_entered_i && res_done_i))
    else $error("entered and dwell_done both set");

  // entry happens only inside the window, exit only outside it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_entered_i || res_done_i) |->
      (res_in_range_i == res_entered_i))
    else $error("tracking change disagrees with window state");

  // an entry reports the distance it stored
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_entered_i |-> (res_edist_i == res_dist_i))
    else $error("entry distance differs from current distance");

endmodule

bind echo_pulse_range_dwell_tracker epr_checker u_epr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_chan_i    (res_o.result_channel),
  .res_width_i   (res_o.echo_width),
  .res_dist_i    (res_o.distance),
  .res_in_range_i(res_o.in_range),
  .res_entered_i (res_o.entered),
  .res_done_i    (res_o.dwell_done),
  .res_dwell_i   (res_o.dwell_ticks),
  .res_edist_i   (res_o.entry_distance)
);

// File: sim/echo_pulse_range_dwell_tracker_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the echo range/dwell tracker: a directed table, then random
// phases under several range windows, scored against typed rows or an in-bench tracker
// model. Depends on epr_pkg, the epr_*_if channel interfaces and the tracker RTL.
module echo_pulse_range_dwell_tracker_tb;
  import epr_pkg::*;

  // operation code the block leaves unused, and register indexes with no register
  localparam logic [OpW-1:0]     OpSpare   = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpare3 = 2'd3;

  localparam int MaxDist       = 11140;  // distance of the widest possible pulse
  localparam int MaxGap        = 10;
  localparam int HoldOffCycles = 300;    // long result stall that backs up the pipe
  localparam int DrainCycles   = 8;      // extra watch for stray results after the drain
  localparam int NumPhases     = 8;
  localparam int PhaseItems    = 194;

  // one expected result transaction
  typedef struct packed {
    logic [ChanW-1:0]  chan;
    logic [CountW-1:0] width;
    logic [DistW-1:0]  dist_cm;
    logic              in_rng;
    logic              entered;
    logic              done;
    logic [TickW-1:0]  dwell;
    logic [DistW-1:0]  entry_dist;
  } echo_res_t;

  // one row of the directed table; typed rows carry a hand-written result
  typedef struct {
    logic [OpW-1:0]    op;
    logic [ChanW-1:0]  ch;
    logic              lvl;
    logic [CountW-1:0] cnt;
    logic [TickW-1:0]  tick;
    bit                typed;
    echo_res_t         res;
  } stim_row_t;

  localparam echo_res_t NoExp = '0;

  logic clk_i;
  logic rst_ni;

  epr_in_if  in_if ();
  epr_res_if res_if ();
  epr_cfg_if cfg_if ();

  echo_pulse_range_dwell_tracker i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // tracker model state: per-channel captures and dwell bookkeeping, plus the window
  logic [CountW-1:0] rise_at       [NumChannels];
  logic [CountW-1:0] fall_at       [NumChannels];
  logic [CountW-1:0] width_at      [NumChannels];
  logic [TickW-1:0]  entry_tick_at [NumChannels];
  logic [DistW-1:0]  entry_dist_at [NumChannels];
  logic [TickW-1:0]  dwell_at      [NumChannels];
  logic [DistW-1:0]  win_low;
  logic [DistW-1:0]  win_high;

  echo_res_t         pending_results [$];  // results owed by the block, oldest first
  stim_row_t         dir_rows [$];
  logic [TickW-1:0]  tick_clk;             // running millisecond tick for random items
  int                in_max_gap;
  int                out_max_gap;
  bit                hold_off_req;
  int                err_count;

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // distance in cm of a pulse width in microseconds, truncated
  function automatic logic [DistW-1:0] echo_distance(input logic [CountW-1:0] w);
    int p;
    p = (int'(w) * 34) / 200;
    return DistW'(p);
  endfunction

  function automatic logic window_has(input logic [DistW-1:0] d);
    return (d > win_low) && (d <= win_high);
  endfunction

  // apply one item to the model and return the result it owes
  function automatic echo_res_t track_echo(input logic [OpW-1:0] op,
                                           input logic [ChanW-1:0] ch,
                                           input logic lvl,
                                           input logic [CountW-1:0] cnt,
                                           input logic [TickW-1:0] tick);
    echo_res_t r;
    logic [DistW-1:0] d;
    r = '0;
    r.chan = ch;
    case (op)
      OpEdge: begin
        if (lvl) begin
          rise_at[ch] = cnt;
        end else begin
          fall_at[ch] = cnt;
          // no rise seen since the last trigger: the width collapses to zero;
          // a fall at or before the rise keeps the old width
          if (rise_at[ch] == '0) width_at[ch] = '0;
          else if (rise_at[ch] < fall_at[ch]) width_at[ch] = fall_at[ch] - rise_at[ch];
        end
      end
      OpTrig: begin
        for (int k = 0; k < NumChannels; k++) begin
          rise_at[k] = '0;
          fall_at[k] = '0;
        end
      end
      OpRange: begin
        d = echo_distance(width_at[ch]);
        // an entry at tick zero is reported but leaves the channel untracked
        if (entry_tick_at[ch] == '0 && window_has(d)) begin
          entry_tick_at[ch] = tick;
          entry_dist_at[ch] = d;
          r.entered = 1'b1;
        end else if (entry_tick_at[ch] != '0 && !window_has(d)) begin
          dwell_at[ch] = tick - entry_tick_at[ch];
          entry_tick_at[ch] = '0;
          r.done = 1'b1;
        end
      end
      default: ;
    endcase
    r.width = width_at[ch];
    r.dist_cm = echo_distance(width_at[ch]);
    r.in_rng = window_has(r.dist_cm);
    r.dwell = dwell_at[ch];
    r.entry_dist = entry_dist_at[ch];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
    err_count++;
  endtask

  // offer one item after a random gap, hold it until accepted, then log its result
  task automatic send_echo_item(input logic [OpW-1:0] op, input logic [ChanW-1:0] ch,
                                input logic lvl, input logic [CountW-1:0] cnt,
                                input logic [TickW-1:0] tick, input bit typed,
                                input echo_res_t typed_res);
    int gap;
    echo_res_t r;
    gap = $urandom_range(0, in_max_gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.operation   <= op;
    in_if.channel     <= ch;
    in_if.echo_level  <= lvl;
    in_if.timer_count <= cnt;
    in_if.tick_now    <= tick;
    do @(posedge clk_i); while (!in_if.ready);
    r = track_echo(op, ch, lvl, cnt, tick);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  // one register write; leaves valid high so writes can go back to back
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DistW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == CfgRangeLow) win_low = val;
    else if (idx == CfgRangeHigh) win_high = val;
  endtask

  // drain every pending result, then rewrite the window while the block is idle
  task automatic settle_and_configure(input logic [DistW-1:0] lo, input logic [DistW-1:0] hi,
                                      input bit with_spares);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    if (with_spares) begin
      // writes to unmapped indexes must leave the window alone
      write_reg(CfgSpare2, DistW'($urandom()));
      write_reg(CfgSpare3, DistW'($urandom()));
    end
    write_reg(CfgRangeLow, lo);
    write_reg(CfgRangeHigh, hi);
    cfg_if.valid <= 1'b0;
  endtask

  // mostly rise/fall/range-update sequences aimed at the window edges, plus noise
  task automatic run_random_phase(input int n_items);
    int sent;
    int kind;
    int d;
    int w;
    int rise;
    logic [ChanW-1:0] ch;
    logic [TickW-1:0] t;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      ch = ChanW'($urandom_range(0, NumChannels - 1));
      tick_clk += TickW'($urandom_range(1, 3000));
      if ($urandom_range(0, 80) == 0) tick_clk = 32'hFFFF_F000 + TickW'($urandom_range(0, 255));
      t = ($urandom_range(0, 19) == 0) ? '0 : tick_clk;
      if (kind < 6) begin
        // pick a target distance, then the narrowest width for it plus up to five
        case ($urandom_range(0, 3))
          0:       d = int'(win_low) + $urandom_range(0, 2) - 1;
          1:       d = int'(win_high) + $urandom_range(0, 2) - 1;
          2:       d = $urandom_range(0, MaxDist);
          default: d = $urandom_range(0, 1200);
        endcase
        if (d < 0) d = 0;
        if (d > MaxDist) d = MaxDist;
        w = (d * 200 + 33) / 34 + $urandom_range(0, 5);
        if (w > 65534) w = 65534;
        rise = $urandom_range(1, 65535 - w);
        send_echo_item(OpEdge, ch, 1'b1, CountW'(rise), $urandom(), 1'b0, NoExp);
        send_echo_item(OpEdge, ch, 1'b0, CountW'(rise + w), $urandom(), 1'b0, NoExp);
        send_echo_item(OpRange, ch, 1'($urandom()), CountW'($urandom()), t, 1'b0, NoExp);
        sent += 3;
      end else if (kind == 6) begin
        send_echo_item(OpTrig, ch, 1'($urandom()), CountW'($urandom()), $urandom(),
                       1'b0, NoExp);
        sent++;
      end else if (kind == 7) begin
        send_echo_item(OpW'($urandom_range(0, 3)), ch, 1'($urandom()), CountW'($urandom()),
                       $urandom(), 1'b0, NoExp);
        sent++;
      end else if (kind == 8) begin
        // lone fall: hits the no-rise and fall-before-rise cases
        send_echo_item(OpEdge, ch, 1'b0, CountW'($urandom()), $urandom(), 1'b0, NoExp);
        sent++;
      end else begin
        send_echo_item(OpRange, ch, 1'($urandom()), CountW'($urandom()), t, 1'b0, NoExp);
        sent++;
      end
    end
  endtask

  // result side: random ready gaps, one long hold-off on request, check each transaction
  initial begin : result_sink
    echo_res_t want;
    int gap;
    res_if.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap = HoldOffCycles;
      end else begin
        gap = $urandom_range(0, out_max_gap);
      end
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, channel", res_if.result_channel, -1);
      end else begin
        want = pending_results.pop_front();
        if (res_if.result_channel !== want.chan)
          report_mismatch("result_channel", res_if.result_channel, want.chan);
        if (res_if.echo_width !== want.width)
          report_mismatch("echo_width", res_if.echo_width, want.width);
        if (res_if.distance !== want.dist_cm)
          report_mismatch("distance", res_if.distance, want.dist_cm);
        if (res_if.in_range !== want.in_rng)
          report_mismatch("in_range", res_if.in_range, want.in_rng);
        if (res_if.entered !== want.entered)
          report_mismatch("entered", res_if.entered, want.entered);
        if (res_if.dwell_done !== want.done)
          report_mismatch("dwell_done", res_if.dwell_done, want.done);
        if (res_if.dwell_ticks !== want.dwell)
          report_mismatch("dwell_ticks", res_if.dwell_ticks, want.dwell);
        if (res_if.entry_distance !== want.entry_dist)
          report_mismatch("entry_distance", res_if.entry_distance, want.entry_dist);
      end
    end
  end

  initial begin : stimulus
    logic [DistW-1:0] lo_tab [NumPhases];
    logic [DistW-1:0] hi_tab [NumPhases];
    logic [DistW-1:0] lo;
    logic [DistW-1:0] hi;

    // drive every input to a known value before reset
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.operation   = '0;
    in_if.channel     = '0;
    in_if.echo_level  = 1'b0;
    in_if.timer_count = '0;
    in_if.tick_now    = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    in_max_gap        = MaxGap;
    out_max_gap       = MaxGap;
    hold_off_req      = 1'b0;
    err_count         = 0;
    win_low           = RangeLowRst;
    win_high          = RangeHighRst;
    for (int k = 0; k < NumChannels; k++) begin
      rise_at[k]       = '0;
      fall_at[k]       = '0;
      width_at[k]      = '0;
      entry_tick_at[k] = '0;
      entry_dist_at[k] = '0;
      dwell_at[k]      = '0;
    end
    tick_clk = $urandom();

    // window per random phase: reset values, full span, nothing reachable, empty,
    // inverted, all-ones, a random one, a moderate one (the hold-off phase)
    lo_tab = '{14'd20, 14'd0, 14'd11140, 14'd0, 14'd500, 14'd16383, 14'd0, 14'd150};
    hi_tab = '{14'd1000, 14'd16383, 14'd11140, 14'd0, 14'd300, 14'd16383, 14'd0, 14'd2000};

    // directed table, run under the reset window
    dir_rows = '{
      // range update straight after reset: all zero
      '{OpRange, 2'd0, 1'b0, 16'd0, 32'd5, 1'b1,
        '{2'd0, 16'd0, 14'd0, 1'b0, 1'b0, 1'b0, 32'd0, 14'd0}},
      // fall with no rise captured: width zero
      '{OpEdge, 2'd1, 1'b0, 16'd500, 32'd0, 1'b1,
        '{2'd1, 16'd0, 14'd0, 1'b0, 1'b0, 1'b0, 32'd0, 14'd0}},
      '{OpEdge, 2'd2, 1'b1, 16'd1, 32'hFFFF_FFFF, 1'b1,
        '{2'd2, 16'd0, 14'd0, 1'b0, 1'b0, 1'b0, 32'd0, 14'd0}},
      // widest pulse: largest distance, out of the window
      '{OpEdge, 2'd2, 1'b0, 16'd65535, 32'd0, 1'b1,
        '{2'd2, 16'd65534, 14'd11140, 1'b0, 1'b0, 1'b0, 32'd0, 14'd0}},
      '{OpRange, 2'd2, 1'b1, 16'd65535, 32'hFFFF_FFFF, 1'b1,
        '{2'd2, 16'd65534, 14'd11140, 1'b0, 1'b0, 1'b0, 32'd0, 14'd0}},
      // distance exactly at the upper bound, then enter near the tick wrap
      '{OpEdge, 2'd3, 1'b1, 16'd1000, 32'd0, 1'b0, NoExp},
      '{OpEdge, 2'd3, 1'b0, 16'd6883, 32'd0, 1'b1,
        '{2'd3, 16'd5883, 14'd1000, 1'b1, 1'b0, 1'b0, 32'd0, 14'd0}},
      '{OpRange, 2'd3, 1'b0, 16'd0, 32'hFFFF_FFF0, 1'b1,
        '{2'd3, 16'd5883, 14'd1000, 1'b1, 1'b1, 1'b0, 32'd0, 14'd1000}},
      // fall before and at the rise: width kept
      '{OpEdge, 2'd3, 1'b1, 16'd2000, 32'd0, 1'b0, NoExp},
      '{OpEdge, 2'd3, 1'b0, 16'd1999, 32'd0, 1'b0, NoExp},
      '{OpEdge, 2'd3, 1'b0, 16'd2000, 32'd0, 1'b0, NoExp},
      // one past the upper bound: leave, dwell wraps through zero
      '{OpEdge, 2'd3, 1'b0, 16'd7889, 32'd0, 1'b0, NoExp},
      '{OpRange, 2'd3, 1'b0, 16'd0, 32'h0000_0010, 1'b0, NoExp},
      // just above and at the lower bound
      '{OpEdge, 2'd3, 1'b1, 16'd100, 32'd0, 1'b0, NoExp},
      '{OpEdge, 2'd3, 1'b0, 16'd224, 32'd0, 1'b0, NoExp},
      '{OpRange, 2'd3, 1'b0, 16'd0, 32'h0000_0020, 1'b0, NoExp},
      '{OpEdge, 2'd3, 1'b0, 16'd223, 32'd0, 1'b0, NoExp},
      '{OpRange, 2'd3, 1'b0, 16'd0, 32'h0000_0030, 1'b0, NoExp},
      // entry at tick zero does not start tracking, so the next update enters again
      '{OpEdge, 2'd0, 1'b1, 16'd10, 32'd0, 1'b0, NoExp},
      '{OpEdge, 2'd0, 1'b0, 16'd1010, 32'd0, 1'b0, NoExp},
      '{OpRange, 2'd0, 1'b0, 16'd0, 32'd0, 1'b0, NoExp},
      '{OpRange, 2'd0, 1'b0, 16'd0, 32'd7, 1'b0, NoExp},
      // trigger clears every capture; a later fall sees no rise
      '{OpTrig, 2'd1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, NoExp},
      '{OpEdge, 2'd3, 1'b0, 16'd500, 32'd0, 1'b0, NoExp},
      // unused operation changes nothing
      '{OpSpare, 2'd0, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, NoExp},
      '{OpRange, 2'd3, 1'b0, 16'd0, 32'h0000_0040, 1'b0, NoExp}
    };

    // hold reset, release it on a clock edge
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_echo_item(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].lvl, dir_rows[i].cnt,
                     dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].res);

    for (int ph = 0; ph < NumPhases; ph++) begin
      lo = lo_tab[ph];
      hi = hi_tab[ph];
      if (ph == 6) begin
        lo = DistW'($urandom_range(0, 3000));
        hi = DistW'($urandom_range(int'(lo), MaxDist));
      end
      // vary the idling: both busy, one side bursty, full back-to-back
      case (ph)
        1, 5:    begin in_max_gap = 0;      out_max_gap = 0;      end
        3:       begin in_max_gap = 0;      out_max_gap = MaxGap; end
        6:       begin in_max_gap = MaxGap; out_max_gap = 0;      end
        7:       begin in_max_gap = 0;      out_max_gap = 2;      end
        default: begin in_max_gap = MaxGap; out_max_gap = MaxGap; end
      endcase
      settle_and_configure(lo, hi, ph == 2);
      // stall the result side for a long stretch while items keep coming
      if (ph == 7) hold_off_req = 1'b1;
      run_random_phase(PhaseItems);
    end

    // drop valid, drain what is owed, then watch a little longer for strays
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/epr_pkg.sv
hdl/epr_ifs.sv
hdl/echo_pulse_range_dwell_tracker.sv
hdl/epr_checker.sv
sim/echo_pulse_range_dwell_tracker_tb.sv
